### rtl/chained_hash_set_insert_search_core_defines.svh
// Assertion macros shared by the chained hash set RTL.
`ifndef CHAINED_HASH_SET_INSERT_SEARCH_CORE_DEFINES_SVH
`define CHAINED_HASH_SET_INSERT_SEARCH_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define CHS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chained hash set: same-cycle check failed");
// Next-cycle implication, disabled while reset is high.
`define CHS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chained hash set: next-cycle check failed");
`else
`define CHS_ASSERT_IMP(label, clk, rst, ante, cons)
`define CHS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/chs_pkg.sv
// Shared types and constants of the chained hash set.
`default_nettype none
package chs_pkg;

   localparam int unsigned KEY_W     = 31;
   localparam int unsigned CNT_W     = 8;
   localparam int unsigned BKT_OUT_W = 7;
   localparam int unsigned DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd30;

   localparam logic ACT_INSERT  = 1'b0;
   localparam logic ACT_SEARCH  = 1'b1;
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic REG_BUCKET_COUNT = 1'b0;

   typedef struct packed {
      logic load;
      logic div_step;
      logic len_rd;
      logic ins_wr;
      logic slot_rd;
      logic idx_inc;
      logic clear_wr;
      logic finish;
      logic found;
      logic status;
   } chs_cmd_type;

   typedef struct packed {
      logic is_search;
      logic div_last;
      logic len_full;
      logic len_zero;
      logic key_match;
      logic scan_last;
      logic clear_last;
   } chs_stat_type;

endpackage
`default_nettype wire

### rtl/chs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module chs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/chs_ctrl.sv
// Controller state machine of the chained hash set.
`include "chained_hash_set_insert_search_core_defines.svh"
`default_nettype none
module chs_ctrl import chs_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire chs_stat_type stat,
   output chs_cmd_type       cmd
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_DIV   = 7'b0000100,
      S_LREAD = 7'b0001000,
      S_LCHK  = 7'b0010000,
      S_SREAD = 7'b0100000,
      S_SCMP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_LREAD;
            end
         end
         S_LREAD: begin
            cmd.len_rd = 1'b1;
            state_in   = S_LCHK;
         end
         S_LCHK: begin
            if (!stat.is_search) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
               if (stat.len_full) begin
                  cmd.status = STATUS_FULL;
               end else begin
                  cmd.ins_wr = 1'b1;
                  cmd.status = STATUS_DONE;
               end
            end else if (stat.len_zero) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_SREAD;
            end
         end
         S_SREAD: begin
            cmd.slot_rd = 1'b1;
            state_in    = S_SCMP;
         end
         S_SCMP: begin
            if (stat.key_match) begin
               cmd.finish = 1'b1;
               cmd.found  = 1'b1;
               state_in   = S_IDLE;
            end else if (stat.scan_last) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SREAD;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   `CHS_ASSERT_NXT(a_start_takes_busy, clock, reset, start && !busy, busy)
   `CHS_ASSERT_IMP(a_finish_not_idle, clock, reset, cmd.finish, busy)

endmodule
`default_nettype wire

### rtl/chs_dp.sv
// Datapath of the chained hash set: serial modulo, chain memories and result register.
`include "chained_hash_set_insert_search_core_defines.svh"
`default_nettype none
module chs_dp import chs_pkg::*; #(
   parameter int unsigned BUCKETS = 128,
   parameter int unsigned SLOTS   = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_action,
   input  wire logic [KEY_W-1:0]     req_key,
   input  wire logic [CNT_W-1:0]     bucket_count,
   input  wire chs_cmd_type          cmd,
   output chs_stat_type              stat,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic [BKT_OUT_W-1:0]      rsp_bucket,
   output logic                      rsp_status
);

   localparam int unsigned BW  = $clog2(BUCKETS);
   localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned LW  = $clog2(SLOTS + 1);
   localparam int unsigned CAP = (BUCKETS > 255) ? 255 : BUCKETS;
   localparam logic [CNT_W-1:0] CAP_N    = CAP[CNT_W-1:0];
   localparam logic [LW-1:0]    SLOTS_L  = SLOTS[LW-1:0];
   localparam logic [BW-1:0]    LAST_BKT = BW'(BUCKETS - 1);

   logic                 action_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [KEY_W-1:0]     div_ff;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     n_ff, eff_n;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [LW-1:0]        idx_ff;
   logic [BW-1:0]        clr_cnt_ff;
   logic                 rsp_valid_ff, rsp_found_ff, rsp_status_ff;
   logic [BKT_OUT_W-1:0] rsp_bucket_ff;

   logic [CNT_W:0]       trial;
   logic [BW-1:0]        bucket_idx;
   logic [LW-1:0]        len_rdata;
   logic [KEY_W-1:0]     slot_rdata;

   // Zero means one bucket; counts above the table size saturate.
   always_comb begin
      if (bucket_count == '0) begin
         eff_n = CNT_W'(1);
      end else if (bucket_count > CAP_N) begin
         eff_n = CAP_N;
      end else begin
         eff_n = bucket_count;
      end
   end

   // One restoring step: bring in the next key bit and subtract if possible.
   assign trial = {rem_ff, div_ff[KEY_W-1]};
   always_comb begin
      if (trial >= {1'b0, n_ff}) begin
         rem_in = CNT_W'(trial - {1'b0, n_ff});
      end else begin
         rem_in = trial[CNT_W-1:0];
      end
   end

   assign bucket_idx = BW'(rem_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         key_ff    <= req_key;
         div_ff    <= req_key;
         rem_ff    <= '0;
         n_ff      <= eff_n;
      end else if (cmd.div_step) begin
         div_ff <= {div_ff[KEY_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
      if (cmd.finish) begin
         rsp_found_ff  <= cmd.found;
         rsp_status_ff <= cmd.status;
         rsp_bucket_ff <= rem_ff[BKT_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff   <= '0;
         idx_ff       <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.load) begin
            div_cnt_ff <= '0;
            idx_ff     <= '0;
         end else begin
            if (cmd.div_step) begin
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
            end
            if (cmd.idx_inc) begin
               idx_ff <= idx_ff + LW'(1);
            end
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + BW'(1);
         end
      end
   end

   chs_ram #(
      .WIDTH (LW),
      .DEPTH (BUCKETS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (cmd.clear_wr | cmd.ins_wr),
      .wr_addr (cmd.clear_wr ? clr_cnt_ff : bucket_idx),
      .wr_data (cmd.clear_wr ? '0 : (len_rdata + LW'(1))),
      .rd_en   (cmd.len_rd),
      .rd_addr (bucket_idx),
      .rd_data (len_rdata)
   );

   chs_ram #(
      .WIDTH (KEY_W),
      .DEPTH (BUCKETS << SW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.ins_wr),
      .wr_addr ({bucket_idx, len_rdata[SW-1:0]}),
      .wr_data (key_ff),
      .rd_en   (cmd.slot_rd),
      .rd_addr ({bucket_idx, idx_ff[SW-1:0]}),
      .rd_data (slot_rdata)
   );

   always_comb begin
      stat.is_search  = (action_ff == ACT_SEARCH);
      stat.div_last   = (div_cnt_ff == DIV_LAST);
      stat.len_full   = (len_rdata >= SLOTS_L);
      stat.len_zero   = (len_rdata == '0);
      stat.key_match  = (slot_rdata == key_ff);
      stat.scan_last  = ((idx_ff + LW'(1)) == len_rdata);
      stat.clear_last = (clr_cnt_ff == LAST_BKT);
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_bucket = rsp_bucket_ff;
   assign rsp_status = rsp_status_ff;

   `CHS_ASSERT_IMP(a_bucket_below_count, clock, reset, cmd.len_rd, rem_ff < n_ff)
   `CHS_ASSERT_IMP(a_full_not_found, clock, reset, rsp_valid && rsp_status, !rsp_found)

endmodule
`default_nettype wire

### rtl/chained_hash_set_insert_search_core.sv
// Top level of the chained hash set with insert and search by key.
//
//   Channel   Ports                               Handshake
//   --------  ----------------------------------  -------------------------------
//   request   req_action, req_key                 taken when start and not busy
//   result    rsp_found, rsp_bucket, rsp_status   one-cycle strobe on rsp_valid
//   config    psel, penable, pwrite, paddr, ...   APB read and write, pready always high
//
// Each accepted word is hashed by a bit-serial restoring modulo, one key bit a cycle
// over all 31 key bits; then the bucket's length is read and the word is decided.
// An insert, or a search of an empty chain, ends there; any other search reads and
// compares the chain's slots one at a time until a key matches or the chain ends.
// busy drops with the strobe, so the block takes no new word before the last result.
// After reset busy stays high while every bucket length is cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`default_nettype none
module chained_hash_set_insert_search_core import chs_pkg::*; #(
   parameter int unsigned BUCKETS = 128,
   parameter int unsigned SLOTS   = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_action,
   input  wire logic [KEY_W-1:0]     req_key,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic [BKT_OUT_W-1:0]      rsp_bucket,
   output logic                      rsp_status,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic [CNT_W-1:0] bucket_count_ff;
   logic             reg_sel;
   chs_cmd_type      cmd;
   chs_stat_type     stat;

   // Register index comes from the word address; only index zero exists.
   assign reg_sel = (paddr[2] == REG_BUCKET_COUNT);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= CNT_W'(7);
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         bucket_count_ff <= pwdata[CNT_W-1:0];
      end
   end

   always_comb begin
      if (reg_sel) begin
         prdata = {{(32 - CNT_W){1'b0}}, bucket_count_ff};
      end else begin
         prdata = '0;
      end
   end

   chs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   chs_dp #(
      .BUCKETS (BUCKETS),
      .SLOTS   (SLOTS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_action   (req_action),
      .req_key      (req_key),
      .bucket_count (bucket_count_ff),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_bucket   (rsp_bucket),
      .rsp_status   (rsp_status)
   );

endmodule
`default_nettype wire

### test/chained_hash_set_insert_search_core_tb.sv
// Self-checking testbench of the chained hash set insert and search core.
`default_nettype none
module chained_hash_set_insert_search_core_tb import chs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BUCKETS = 128;
   localparam int unsigned SLOTS   = 8;

   // Register map: register index i sits at byte address 4*i. Index 1 lies
   // beyond the register list, so a write there must change nothing.
   localparam logic [2:0] ADDR_BUCKET_COUNT = {REG_BUCKET_COUNT, 2'b00};
   localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;

   // The slowest word is a search over a full chain. The watchdog allows
   // for that, the clearing pass after reset, and the longest sender gap,
   // several times over.
   localparam int unsigned ITEM_LATENCY   = 34 + 2 * SLOTS;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned PHASES         = 12;
   localparam int unsigned PHASE_ITEMS    = 115;
   localparam int unsigned MAX_REPORTS    = 10;

   typedef struct packed {
      logic                 found;
      logic [BKT_OUT_W-1:0] bucket;
      logic                 status;
   } hs_result_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_INSERT, ROW_SEARCH} row_kind_type;

   // One row of the directed table: a register write or a request word.
   // Where typed is set, the expected result word is given in the row itself.
   typedef struct packed {
      row_kind_type         kind;
      logic [2:0]           addr;
      logic [31:0]          value;
      logic                 typed;
      logic                 exp_found;
      logic [BKT_OUT_W-1:0] exp_bucket;
      logic                 exp_status;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_action = ACT_INSERT;
   logic [KEY_W-1:0]     req_key = '0;
   logic                 rsp_valid;
   logic                 rsp_found;
   logic [BKT_OUT_W-1:0] rsp_bucket;
   logic                 rsp_status;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [2:0]           paddr = '0;
   logic [31:0]          pwdata = '0;
   logic [31:0]          prdata;
   logic                 pready;

   // Our own copy of the hash set: the divisor register, the chain lengths
   // and the keys held in each chain, in insertion order.
   logic [CNT_W-1:0]     bucket_count_q;
   logic [3:0]           chain_len [BUCKETS];
   logic [KEY_W-1:0]     chain_keys [BUCKETS][SLOTS];
   logic [KEY_W-1:0]     held_keys [$];
   hs_result_type        expected_results [$];
   hs_result_type        rsp_expected;
   hs_result_type        rsp_actual;
   dir_row_type          dir_rows [$];
   int unsigned          fail_count = 0;
   int unsigned          stall_cycles = 0;

   chained_hash_set_insert_search_core #(
      .BUCKETS (BUCKETS),
      .SLOTS   (SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_action (req_action),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_found  (rsp_found),
      .rsp_bucket (rsp_bucket),
      .rsp_status (rsp_status),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic note_failure(string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("mismatch %0d at %0t: %s", fail_count, $realtime, what);
      end
   endtask

   // The divisor in force: zero acts as one and anything above the table
   // size saturates to the table size.
   function automatic int unsigned live_buckets();
      int unsigned n;
      n = 32'(bucket_count_q);
      if (n == 0) n = 1;
      if (n > BUCKETS) n = BUCKETS;
      return n;
   endfunction

   // Applies one request word to our copy of the set and returns the result
   // word the block should produce for it.
   function automatic hs_result_type hash_set_apply(logic action, logic [KEY_W-1:0] key);
      hs_result_type res;
      int unsigned   b;
      int unsigned   len;
      b   = 32'(key) % live_buckets();
      len = 32'(chain_len[b]);
      if (len > SLOTS) len = SLOTS;
      res.found  = 1'b0;
      res.bucket = BKT_OUT_W'(b);
      res.status = STATUS_DONE;
      if (action == ACT_INSERT) begin
         // A full chain refuses the key and stores nothing.
         if (len >= SLOTS) begin
            res.status = STATUS_FULL;
         end else begin
            chain_keys[b][len] = key;
            chain_len[b]       = 4'(len + 1);
            held_keys.push_back(key);
         end
      end else begin
         for (int i = 0; i < len; i++) begin
            if (chain_keys[b][i] == key) begin
               res.found = 1'b1;
               break;
            end
         end
      end
      return res;
   endfunction

   // Sender gaps: mostly none or short, now and then a long one. Burst
   // phases send back to back so that words meet the block with no rest.
   function automatic int unsigned pick_gap(bit burst);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (burst || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // Keys are drawn so that searches often hit a held key, or miss with a
   // key that lands in the same bucket as one; inserts bring duplicates,
   // small keys that pile up in a few buckets, and the extremes.
   function automatic logic [KEY_W-1:0] pick_key(logic action);
      int unsigned      r;
      int unsigned      hit_share;
      logic [KEY_W-1:0] k;
      r         = $urandom_range(0, 99);
      hit_share = (action == ACT_SEARCH) ? 50 : 10;
      k         = KEY_W'($urandom);
      if (held_keys.size() != 0 && r < hit_share) begin
         k = held_keys[$urandom_range(0, held_keys.size() - 1)];
      end else if (held_keys.size() != 0 && action == ACT_SEARCH && r < 70) begin
         k = held_keys[$urandom_range(0, held_keys.size() - 1)] + KEY_W'(live_buckets());
      end else if (r < 80) begin
         k = KEY_W'($urandom_range(0, 1000));
      end else if (r < 88) begin
         k = (r % 2 == 0) ? '1 : '0;
      end
      return k;
   endfunction

   // Presents one request word and holds it until the block takes it. The
   // expectation is queued at the edge that accepts the word.
   task automatic send_word(logic action, logic [KEY_W-1:0] key, logic typed,
                            hs_result_type typed_result);
      hs_result_type predicted;
      @(negedge clock);
      start      = 1'b1;
      req_action = action;
      req_key    = key;
      do @(posedge clock); while (busy);
      predicted = hash_set_apply(action, key);
      expected_results.push_back(typed ? typed_result : predicted);
   endtask

   // Lowers start for the given number of cycles, with junk on the fields.
   task automatic idle_gap(int unsigned cycles);
      if (cycles == 0) return;
      @(negedge clock);
      start      = 1'b0;
      req_action = 1'($urandom);
      req_key    = KEY_W'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stops sending and waits until every expected result word has come.
   // Every word yields a result, so an empty queue means the block is idle.
   task automatic drain_results();
      if (start) begin
         @(negedge clock);
         start = 1'b0;
      end
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_BUCKET_COUNT) bucket_count_q = data[CNT_W-1:0];
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // APB read of the bucket count, checked against our copy.
   task automatic csr_read_check();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = ADDR_BUCKET_COUNT;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(bucket_count_q)) begin
         note_failure($sformatf("bucket_count read: expected 0x%0h, got 0x%0h",
                                bucket_count_q, prdata));
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Register changes happen only with the block idle.
   task automatic reconfigure(logic [2:0] addr, logic [31:0] data);
      drain_results();
      csr_write(addr, data);
      csr_read_check();
   endtask

   // Result checker: each strobed word is compared with the oldest
   // expectation, all three fields at once.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         rsp_actual = '{rsp_found, rsp_bucket, rsp_status};
         if (expected_results.size() == 0) begin
            note_failure($sformatf("result word found=%0d bucket=%0d status=%0d not expected",
                                   rsp_found, rsp_bucket, rsp_status));
         end else begin
            rsp_expected = expected_results.pop_front();
            if (rsp_actual !== rsp_expected) begin
               note_failure($sformatf(
                  "result word: expected found=%0d bucket=%0d status=%0d, got %0d %0d %0d",
                  rsp_expected.found, rsp_expected.bucket, rsp_expected.status,
                  rsp_found, rsp_bucket, rsp_status));
            end
         end
      end
   end

   // Watchdog: any cycle in which a request word, a result word or a
   // register access goes through restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("chained_hash_set_insert_search_core_tb failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      dir_row_type      row;
      int unsigned      divisor;
      logic             action;
      bit               burst;
      int unsigned      gap;

      bucket_count_q = 8'd7;
      foreach (chain_len[b]) chain_len[b] = '0;

      // Directed part. The divisor starts at its reset value of 7.
      // Both key extremes go in and are found again.
      dir_rows.push_back('{ROW_INSERT, ADDR_BUCKET_COUNT, 32'h0, 1'b1, 1'b0, 7'd0, STATUS_DONE});
      dir_rows.push_back('{ROW_SEARCH, ADDR_BUCKET_COUNT, 32'h0, 1'b1, 1'b1, 7'd0, STATUS_DONE});
      dir_rows.push_back('{ROW_SEARCH, ADDR_BUCKET_COUNT, 32'd7, 1'b1, 1'b0, 7'd0, STATUS_DONE});
      dir_rows.push_back('{ROW_INSERT, ADDR_BUCKET_COUNT, 32'h7FFF_FFFF, 1'b1, 1'b0, 7'd1,
                           STATUS_DONE});
      dir_rows.push_back('{ROW_SEARCH, ADDR_BUCKET_COUNT, 32'h7FFF_FFFF, 1'b1, 1'b1, 7'd1,
                           STATUS_DONE});
      // Duplicates of zero fill bucket 0 to its last slot.
      repeat (SLOTS - 1) begin
         dir_rows.push_back('{ROW_INSERT, ADDR_BUCKET_COUNT, 32'h0, 1'b0, 1'b0, 7'd0,
                              STATUS_DONE});
      end
      // A full chain refuses the insert, and a miss walks the whole chain.
      dir_rows.push_back('{ROW_INSERT, ADDR_BUCKET_COUNT, 32'd7, 1'b1, 1'b0, 7'd0, STATUS_FULL});
      dir_rows.push_back('{ROW_SEARCH, ADDR_BUCKET_COUNT, 32'd7, 1'b1, 1'b0, 7'd0, STATUS_DONE});
      // A count of zero, with junk in the upper data bits, acts as one.
      dir_rows.push_back('{ROW_WRITE, ADDR_BUCKET_COUNT, 32'hFFFF_FF00, 1'b0, 1'b0, 7'd0,
                           STATUS_DONE});
      dir_rows.push_back('{ROW_SEARCH, ADDR_BUCKET_COUNT, 32'd14, 1'b1, 1'b0, 7'd0, STATUS_DONE});
      dir_rows.push_back('{ROW_INSERT, ADDR_BUCKET_COUNT, 32'd5, 1'b1, 1'b0, 7'd0, STATUS_FULL});
      // The largest count saturates to the table size.
      dir_rows.push_back('{ROW_WRITE, ADDR_BUCKET_COUNT, 32'd255, 1'b0, 1'b0, 7'd0, STATUS_DONE});
      dir_rows.push_back('{ROW_INSERT, ADDR_BUCKET_COUNT, 32'd200, 1'b1, 1'b0, 7'd72,
                           STATUS_DONE});
      dir_rows.push_back('{ROW_SEARCH, ADDR_BUCKET_COUNT, 32'd200, 1'b1, 1'b1, 7'd72,
                           STATUS_DONE});
      dir_rows.push_back('{ROW_SEARCH, ADDR_BUCKET_COUNT, 32'h7FFF_FFFF, 1'b1, 1'b0, 7'd127,
                           STATUS_DONE});
      // A write past the register list leaves the divisor alone.
      dir_rows.push_back('{ROW_WRITE, ADDR_UNMAPPED, 32'd3, 1'b0, 1'b0, 7'd0, STATUS_DONE});
      dir_rows.push_back('{ROW_INSERT, ADDR_BUCKET_COUNT, 32'd129, 1'b1, 1'b0, 7'd1,
                           STATUS_DONE});
      // Chains stored under an older divisor stay where they are.
      dir_rows.push_back('{ROW_WRITE, ADDR_BUCKET_COUNT, 32'd128, 1'b0, 1'b0, 7'd0, STATUS_DONE});
      dir_rows.push_back('{ROW_SEARCH, ADDR_BUCKET_COUNT, 32'h0, 1'b1, 1'b1, 7'd0, STATUS_DONE});

      // Synchronous reset, released at a falling edge. The block then clears
      // its chain lengths with busy held high.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      csr_read_check();

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         case (row.kind)
            ROW_WRITE: begin
               reconfigure(row.addr, row.value);
            end
            default: begin
               send_word((row.kind == ROW_SEARCH) ? ACT_SEARCH : ACT_INSERT,
                         row.value[KEY_W-1:0], row.typed,
                         '{row.exp_found, row.exp_bucket, row.exp_status});
               idle_gap(pick_gap(1'b0));
            end
         endcase
      end

      // Random part: phases under different divisors, the fixed ones and extremes first.
      // The set is never cleared, so later phases search and insert into
      // chains filled under earlier divisors and meet many full chains.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       divisor = 7;
            1:       divisor = 128;
            2:       divisor = 1;
            3:       divisor = 255;
            4:       divisor = 0;
            5:       divisor = 2;
            6:       divisor = 129;
            default: divisor = $urandom_range(1, 255);
         endcase
         reconfigure(ADDR_BUCKET_COUNT,
                     {24'($urandom_range(0, 32'h00FF_FFFF)), 8'(divisor)});
         if (p % 5 == 3) begin
            reconfigure(ADDR_UNMAPPED, $urandom);
         end
         burst = (p % 4 == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            action = ($urandom_range(0, 99) < 50) ? ACT_INSERT : ACT_SEARCH;
            send_word(action, pick_key(action), 1'b0, '0);
            // Halfway through some phases the sender waits for every
            // outstanding result before going on.
            if (n == PHASE_ITEMS / 2 && p % 3 == 0) begin
               drain_results();
            end else begin
               gap = pick_gap(burst);
               idle_gap(gap);
            end
         end
      end

      drain_results();
      repeat (ITEM_LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("chained_hash_set_insert_search_core_tb passed");
      end else begin
         $display("chained_hash_set_insert_search_core_tb failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
